/* rtl/point_in_triangle_winding_macros.svh */
// assertion macros shared by the point-in-triangle winding rtl
// expects a clock named clk and a synchronous active-high reset named rst in the user module
`ifndef POINT_IN_TRIANGLE_WINDING_MACROS_SVH
`define POINT_IN_TRIANGLE_WINDING_MACROS_SVH

// same-cycle implication, checked outside reset
`define PITW_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// next-cycle implication, checked outside reset
`define PITW_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

/* rtl/pitw_pkg.sv */
// shared types, codes and helpers for the point-in-triangle winding block
// no dependencies
`default_nettype none

package pitw_pkg;

  localparam int NUM_EDGES  = 3;
  localparam int NUM_DIFFS  = 4;
  localparam int WIND_WIDTH = 4;

  typedef logic [1:0] quad_t;
  typedef logic signed [WIND_WIDTH-1:0] wind_t;

  // quadrant of a vertex relative to the test point
  localparam quad_t QUAD_NE = 2'd0;
  localparam quad_t QUAD_NW = 2'd1;
  localparam quad_t QUAD_SW = 2'd2;
  localparam quad_t QUAD_SE = 2'd3;

  // what one edge contributes, before any arithmetic
  typedef enum logic [1:0] {
    EDGE_NONE,
    EDGE_INC,
    EDGE_DEC,
    EDGE_DIAG
  } edge_kind_t;

  // classification handed from the front to the back
  typedef struct packed {
    logic       reject;
    edge_kind_t kind_20;
    edge_kind_t kind_01;
    edge_kind_t kind_12;
  } class_t;

  function automatic edge_kind_t classify_edge(input quad_t qp, input quad_t qn);
    edge_kind_t kind;
    if (qp == qn) begin
      kind = EDGE_NONE;
    end else if (quad_t'(qp + 2'd1) == qn) begin
      kind = EDGE_INC;
    end else if (quad_t'(qn + 2'd1) == qp) begin
      kind = EDGE_DEC;
    end else begin
      kind = EDGE_DIAG;
    end
    return kind;
  endfunction

endpackage

`default_nettype wire

/* rtl/point_in_triangle_winding.sv */
// top level of the point-in-triangle winding block
// depends on pitw_pkg, pitw_front, pitw_fifo and pitw_back
`default_nettype none

// Point-in-triangle test by quadrant winding. Each transfer on the input
// side carries a test point and three triangle vertices, all signed
// COORD_WIDTH-bit fixed point, and gives exactly one result transfer:
// winding (signed 4-bit sum of the edge steps) and inside_res (winding
// nonzero). A point outside the inclusive bounding box of the vertices gives
// zero for both. The block takes one item per clock cycle, with no gaps,
// while pop stays high on the result side; that rate is set by the back
// pipeline, where each edge has its own pair of multipliers in a single
// product stage. With an empty queue, an input transfer reaches the output
// ports through the front register, the queue, the product stage and then
// the result register. The front and the back are decoupled by a
// QUEUE_DEPTH-entry queue, so a stalled result side keeps taking inputs
// until the result register, the product stage, the queue and the front
// register are all occupied; full then rises. There is no reset-time clearing
// pass and no configuration; the block is ready in the cycle after rst falls.

module point_in_triangle_winding #(
  parameter int COORD_WIDTH = 16,
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                           clk,
  input  wire                           rst,
  // input side
  input  wire                           push,
  output logic                          full,
  input  wire  signed [COORD_WIDTH-1:0] point_x,
  input  wire  signed [COORD_WIDTH-1:0] point_y,
  input  wire  signed [COORD_WIDTH-1:0] vert0_x,
  input  wire  signed [COORD_WIDTH-1:0] vert0_y,
  input  wire  signed [COORD_WIDTH-1:0] vert1_x,
  input  wire  signed [COORD_WIDTH-1:0] vert1_y,
  input  wire  signed [COORD_WIDTH-1:0] vert2_x,
  input  wire  signed [COORD_WIDTH-1:0] vert2_y,
  // result side
  output logic                          empty,
  input  wire                           pop,
  output logic                          inside_res,
  output logic signed [3:0]             winding
);

  // queue entry: classification plus the NUM_EDGES * NUM_DIFFS edge differences
  localparam int DIFF_BITS = pitw_pkg::NUM_EDGES * pitw_pkg::NUM_DIFFS * (COORD_WIDTH + 1);
  localparam int Q_WIDTH   = $bits(pitw_pkg::class_t) + DIFF_BITS;

  typedef logic [pitw_pkg::NUM_EDGES-1:0][pitw_pkg::NUM_DIFFS-1:0][COORD_WIDTH:0] diff_set_t;

  // front to queue
  logic             front_valid;
  logic             q_full;
  pitw_pkg::class_t front_class;
  diff_set_t        front_diff;

  // queue to back
  logic             q_empty;
  logic             back_ready;
  logic [Q_WIDTH-1:0] q_dout;
  pitw_pkg::class_t back_class;
  diff_set_t        back_diff;
  pitw_pkg::wind_t  back_winding;

  pitw_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .vert0_x   (vert0_x),
    .vert0_y   (vert0_y),
    .vert1_x   (vert1_x),
    .vert1_y   (vert1_y),
    .vert2_x   (vert2_x),
    .vert2_y   (vert2_y),
    .out_valid (front_valid),
    .out_ready (!q_full),
    .out_class (front_class),
    .out_diff  (front_diff)
  );

  // the queue lets the front keep classifying while the result side stalls
  pitw_fifo #(
    .WIDTH(Q_WIDTH),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .full  (q_full),
    .din   ({front_class, front_diff}),
    .pop   (back_ready),
    .empty (q_empty),
    .dout  (q_dout)
  );

  assign back_class = q_dout[Q_WIDTH-1 -: $bits(pitw_pkg::class_t)];
  assign back_diff  = q_dout[DIFF_BITS-1:0];

  pitw_back #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (!q_empty),
    .in_ready   (back_ready),
    .in_class   (back_class),
    .in_diff    (back_diff),
    .empty      (empty),
    .pop        (pop),
    .inside_res (inside_res),
    .winding    (back_winding)
  );

  assign winding = back_winding;

endmodule

`default_nettype wire

/* rtl/pitw_front.sv */
// front stage: box reject, vertex quadrants, edge classes and edge differences
// depends on pitw_pkg
`default_nettype none

module pitw_front #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   push,
  output logic                                  full,
  input  wire  signed [COORD_WIDTH-1:0]         point_x,
  input  wire  signed [COORD_WIDTH-1:0]         point_y,
  input  wire  signed [COORD_WIDTH-1:0]         vert0_x,
  input  wire  signed [COORD_WIDTH-1:0]         vert0_y,
  input  wire  signed [COORD_WIDTH-1:0]         vert1_x,
  input  wire  signed [COORD_WIDTH-1:0]         vert1_y,
  input  wire  signed [COORD_WIDTH-1:0]         vert2_x,
  input  wire  signed [COORD_WIDTH-1:0]         vert2_y,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output pitw_pkg::class_t                      out_class,
  output logic [pitw_pkg::NUM_EDGES-1:0][pitw_pkg::NUM_DIFFS-1:0][COORD_WIDTH:0] out_diff
);

  typedef logic [pitw_pkg::NUM_DIFFS-1:0][COORD_WIDTH:0] diffs_t;

  function automatic pitw_pkg::quad_t quadrant(
    input logic signed [COORD_WIDTH-1:0] x,
    input logic signed [COORD_WIDTH-1:0] y,
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py
  );
    pitw_pkg::quad_t q;
    if (x < px) begin
      q = (y < py) ? pitw_pkg::QUAD_SW : pitw_pkg::QUAD_NW;
    end else begin
      q = (y < py) ? pitw_pkg::QUAD_SE : pitw_pkg::QUAD_NE;
    end
    return q;
  endfunction

  // yp-yn, px-xp, xp-xn, yp-py at one extra bit, so each is exact
  function automatic diffs_t edge_diffs(
    input logic signed [COORD_WIDTH-1:0] xp,
    input logic signed [COORD_WIDTH-1:0] yp,
    input logic signed [COORD_WIDTH-1:0] xn,
    input logic signed [COORD_WIDTH-1:0] yn,
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py
  );
    logic signed [COORD_WIDTH:0] exp_, eyp, exn, eyn, epx, epy;
    diffs_t d;
    exp_ = {xp[COORD_WIDTH-1], xp};
    eyp  = {yp[COORD_WIDTH-1], yp};
    exn  = {xn[COORD_WIDTH-1], xn};
    eyn  = {yn[COORD_WIDTH-1], yn};
    epx  = {px[COORD_WIDTH-1], px};
    epy  = {py[COORD_WIDTH-1], py};
    d[0] = eyp - eyn;
    d[1] = epx - exp_;
    d[2] = exp_ - exn;
    d[3] = eyp - epy;
    return d;
  endfunction

  logic            load;
  logic            reject;
  pitw_pkg::quad_t q0, q1, q2;
  logic            valid_next;

  assign full      = out_valid && !out_ready;
  assign load      = push && !full;
  assign valid_next = load || (out_valid && !out_ready);

  // outside the box when beyond every vertex on one axis
  assign reject = (point_x < vert0_x && point_x < vert1_x && point_x < vert2_x) ||
                  (point_x > vert0_x && point_x > vert1_x && point_x > vert2_x) ||
                  (point_y < vert0_y && point_y < vert1_y && point_y < vert2_y) ||
                  (point_y > vert0_y && point_y > vert1_y && point_y > vert2_y);

  assign q0 = quadrant(vert0_x, vert0_y, point_x, point_y);
  assign q1 = quadrant(vert1_x, vert1_y, point_x, point_y);
  assign q2 = quadrant(vert2_x, vert2_y, point_x, point_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_class.reject  <= reject;
      out_class.kind_20 <= pitw_pkg::classify_edge(q2, q0);
      out_class.kind_01 <= pitw_pkg::classify_edge(q0, q1);
      out_class.kind_12 <= pitw_pkg::classify_edge(q1, q2);
      out_diff[0] <= edge_diffs(vert2_x, vert2_y, vert0_x, vert0_y, point_x, point_y);
      out_diff[1] <= edge_diffs(vert0_x, vert0_y, vert1_x, vert1_y, point_x, point_y);
      out_diff[2] <= edge_diffs(vert1_x, vert1_y, vert2_x, vert2_y, point_x, point_y);
    end
  end

endmodule

`default_nettype wire

/* rtl/pitw_fifo.sv */
// small first-word-fall-through queue between the front and the back
// depends on point_in_triangle_winding_macros.svh
`default_nettype none
`include "point_in_triangle_winding_macros.svh"

module pitw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  output logic             full,
  input  wire  [WIDTH-1:0] din,
  input  wire              pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_en, rd_en;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CW'(1);
      end else if (rd_en && !wr_en) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= din;
    end
  end

  `PITW_ASSERT_NEXT(a_count_up, wr_en && !rd_en, count == $past(count) + CW'(1), "fifo count did not rise")
  `PITW_ASSERT_NEXT(a_count_hold, wr_en && rd_en, count == $past(count), "fifo count moved on a pass-through")
  `PITW_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(DEPTH), "fifo count beyond depth")

endmodule

`default_nettype wire

/* rtl/pitw_back.sv */
// back pipeline: edge products, diagonal sign test, winding sum and result register
// depends on pitw_pkg and point_in_triangle_winding_macros.svh
`default_nettype none
`include "point_in_triangle_winding_macros.svh"

module pitw_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  pitw_pkg::class_t                      in_class,
  input  wire  [pitw_pkg::NUM_EDGES-1:0][pitw_pkg::NUM_DIFFS-1:0][COORD_WIDTH:0] in_diff,
  output logic                                  empty,
  input  wire                                   pop,
  output logic                                  inside_res,
  output pitw_pkg::wind_t                       winding
);

  localparam int PROD_WIDTH = 2 * COORD_WIDTH + 2;
  localparam int SUM_WIDTH  = PROD_WIDTH + 1;

  logic                         s1_valid, s2_valid;
  logic                         s1_load, s2_load;
  pitw_pkg::class_t             s1_class;
  logic signed [PROD_WIDTH-1:0] prod_a [pitw_pkg::NUM_EDGES];
  logic signed [PROD_WIDTH-1:0] prod_b [pitw_pkg::NUM_EDGES];
  pitw_pkg::edge_kind_t         kind [pitw_pkg::NUM_EDGES];
  logic signed [2:0]            step [pitw_pkg::NUM_EDGES];
  pitw_pkg::wind_t              wind_sum;

  assign s2_load  = !s2_valid || pop;
  assign s1_load  = !s1_valid || s2_load;
  assign in_ready = s1_load;
  assign empty    = !s2_valid;

  // stage 1: two exact products per edge
  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_class <= in_class;
      for (int e = 0; e < pitw_pkg::NUM_EDGES; e++) begin
        prod_a[e] <= $signed(in_diff[e][0]) * $signed(in_diff[e][1]);
        prod_b[e] <= $signed(in_diff[e][2]) * $signed(in_diff[e][3]);
      end
    end
  end

  assign kind[0] = s1_class.kind_20;
  assign kind[1] = s1_class.kind_01;
  assign kind[2] = s1_class.kind_12;

  // stage 2: per-edge step, diagonal sign from the summed products
  for (genvar g = 0; g < pitw_pkg::NUM_EDGES; g++) begin : g_edge
    logic signed [SUM_WIDTH-1:0] cross_sum;
    logic                        positive;

    assign cross_sum = SUM_WIDTH'(prod_a[g]) + SUM_WIDTH'(prod_b[g]);
    assign positive  = !cross_sum[SUM_WIDTH-1] && (cross_sum != '0);

    always_comb begin
      unique case (kind[g])
        pitw_pkg::EDGE_NONE: step[g] = 3'sd0;
        pitw_pkg::EDGE_INC:  step[g] = 3'sd1;
        pitw_pkg::EDGE_DEC:  step[g] = -3'sd1;
        pitw_pkg::EDGE_DIAG: step[g] = positive ? 3'sd2 : -3'sd2;
        default:             step[g] = 3'sd0;
      endcase
    end
  end

  assign wind_sum = pitw_pkg::wind_t'({step[0][2], step[0]}) +
                    pitw_pkg::wind_t'({step[1][2], step[1]}) +
                    pitw_pkg::wind_t'({step[2][2], step[2]});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= in_valid;
      end
      if (s2_load) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      if (s1_class.reject) begin
        inside_res <= 1'b0;
        winding    <= '0;
      end else begin
        inside_res <= (wind_sum != '0);
        winding    <= wind_sum;
      end
    end
  end

  `PITW_ASSERT_NEXT(a_reject_zero, s1_valid && s2_load && s1_class.reject, !inside_res && winding == '0, "rejected item gave a nonzero result")
  `PITW_ASSERT_NOW(a_inside_match, s2_valid, inside_res == (winding != '0), "inside flag disagrees with winding")
  `PITW_ASSERT_NEXT(a_stage_advance, s1_valid && s2_load, s2_valid, "item lost between back stages")

endmodule

`default_nettype wire

/* dv/tb.sv */
// self-checking testbench for point_in_triangle_winding
// depends on pitw_pkg and the point_in_triangle_winding rtl; reads no files

module tb;

  localparam int COORD_W         = 16;
  localparam int RANDOM_ITEMS    = 1350;
  localparam int NUM_ROWS        = 19;
  // receiver hold-off long enough to fill front, queue and back completely
  localparam int HOLD_OFF_CYCLES = 64;
  // cycles without any transfer before the run is declared hung
  localparam int IDLE_LIMIT      = 2000;
  // time for stray results to show up after the last verdict is matched
  localparam int DRAIN_CYCLES    = 12;

  typedef logic signed [COORD_W-1:0] coord_t;

  // one triangle query as it crosses the input side
  typedef struct packed {
    coord_t px, py;
    coord_t x0, y0;
    coord_t x1, y1;
    coord_t x2, y2;
  } tri_item_t;

  // one result as it crosses the result side
  typedef struct packed {
    logic            in_tri;
    pitw_pkg::wind_t wind;
  } verdict_t;

  // directed row: coordinates, plus a typed answer where it is obvious
  typedef struct {
    int px, py, x0, y0, x1, y1, x2, y2;
    bit typed;
    bit in_tri;
    int wind;
  } stim_row_t;

  // how the test point is placed against the random triangle
  typedef enum {SHAPE_BOX, SHAPE_CENTROID, SHAPE_VERTEX, SHAPE_FREE} shape_t;
  // spread of the random vertex coordinates
  typedef enum {SCALE_FULL, SCALE_SMALL, SCALE_EXTREME} scale_t;

  localparam int EXTREME_VALS [8] = '{-32768, -32767, -2, -1, 0, 1, 32766, 32767};

  // clock, reset and dut ports; the ones the bench drives are known from time zero
  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   push = 1'b0;
  logic   pop = 1'b0;
  coord_t point_x = '0;
  coord_t point_y = '0;
  coord_t vert0_x = '0;
  coord_t vert0_y = '0;
  coord_t vert1_x = '0;
  coord_t vert1_y = '0;
  coord_t vert2_x = '0;
  coord_t vert2_y = '0;
  logic              full;
  logic              empty;
  logic              inside_res;
  logic signed [3:0] winding;

  // verdicts waiting for their result transfer, oldest first
  verdict_t winding_q [$];
  int       errors        = 0;
  int       items_sent    = 0;
  int       results_taken = 0;
  int       idle_cycles   = 0;

  // directed part: reject on each side of the box, all-equal corners,
  // both orientations, point on a vertex and on the box edge, full-range
  // triangles for the widest products, a diagonal edge through the point,
  // collinear and single-point triangles, alternating bit patterns
  stim_row_t dir_rows [NUM_ROWS] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 0},
    '{11, 0, 0, 0, 10, 0, 0, 10, 1'b1, 1'b0, 0},
    '{-32768, 5, 0, 0, 10, 0, 0, 10, 1'b1, 1'b0, 0},
    '{0, -1, 0, 0, 10, 0, 0, 10, 1'b1, 1'b0, 0},
    '{0, 11, 0, 0, 10, 0, 0, 10, 1'b1, 1'b0, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b1, 1'b0, 0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b1, 1'b0, 0},
    '{5, 6, 5, 5, 5, 5, 5, 5, 1'b1, 1'b0, 0},
    '{0, 0, -10, -10, 10, -10, 0, 10, 1'b0, 1'b0, 0},
    '{0, 0, -10, -10, 0, 10, 10, -10, 1'b0, 1'b0, 0},
    '{-10, -10, -10, -10, 10, -10, 0, 10, 1'b0, 1'b0, 0},
    '{10, 0, -10, -10, 10, -10, 0, 10, 1'b0, 1'b0, 0},
    '{-100, -100, -32768, -32768, 32767, -32768, -32768, 32767, 1'b0, 1'b0, 0},
    '{100, 100, 32767, 32767, -32768, 32767, 32767, -32768, 1'b0, 1'b0, 0},
    '{0, 0, -10, -10, 10, 10, 10, -10, 1'b0, 1'b0, 0},
    '{0, 0, -5, -5, 5, 5, 0, 0, 1'b0, 1'b0, 0},
    '{-1, -1, -32768, 32767, 32767, -32768, 32767, 32767, 1'b0, 1'b0, 0},
    '{32767, -32768, -32768, -32768, 32767, -32768, -32768, 32767, 1'b0, 1'b0, 0},
    '{0, 0, 21845, -21846, -21846, 21845, 21845, 21845, 1'b0, 1'b0, 0}
  };

  point_in_triangle_winding #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .point_x   (point_x),
    .point_y   (point_y),
    .vert0_x   (vert0_x),
    .vert0_y   (vert0_y),
    .vert1_x   (vert1_x),
    .vert1_y   (vert1_y),
    .vert2_x   (vert2_x),
    .vert2_y   (vert2_y),
    .empty     (empty),
    .pop       (pop),
    .inside_res(inside_res),
    .winding   (winding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // winding predictor
  // ---------------------------------------------------------------------

  // quadrant of a vertex seen from the test point; ties go east and north
  function automatic pitw_pkg::quad_t quadrant_of(longint x, longint y, longint px,
                                                  longint py);
    if (x < px) return (y < py) ? pitw_pkg::QUAD_SW : pitw_pkg::QUAD_NW;
    return (y < py) ? pitw_pkg::QUAD_SE : pitw_pkg::QUAD_NE;
  endfunction

  // winding change along one edge from p to n
  function automatic int edge_turn(pitw_pkg::quad_t qp, pitw_pkg::quad_t qn,
                                   longint xp, longint yp, longint xn, longint yn,
                                   longint px, longint py);
    pitw_pkg::quad_t step;
    longint          cross_val;
    step      = qn - qp;
    // a 35-bit exact value at most, so a longint holds it without loss
    cross_val = (yp - yn) * (px - xp) + (xp - xn) * (yp - py);
    case (step)
      2'd0: return 0;
      2'd1: return 1;
      2'd3: return -1;
      // diagonal: the sign of the line test picks the direction, zero counts as minus
      default: return (cross_val > 0) ? 2 : -2;
    endcase
  endfunction

  function automatic verdict_t predict_winding(tri_item_t t);
    longint          px, py, x0, y0, x1, y1, x2, y2;
    pitw_pkg::quad_t q0, q1, q2;
    int              sum;
    verdict_t        v;
    px = t.px; py = t.py;
    x0 = t.x0; y0 = t.y0;
    x1 = t.x1; y1 = t.y1;
    x2 = t.x2; y2 = t.y2;
    // inclusive bounding box reject
    if ((px < x0 && px < x1 && px < x2) || (px > x0 && px > x1 && px > x2) ||
        (py < y0 && py < y1 && py < y2) || (py > y0 && py > y1 && py > y2)) begin
      v.in_tri = 1'b0;
      v.wind   = '0;
      return v;
    end
    q0  = quadrant_of(x0, y0, px, py);
    q1  = quadrant_of(x1, y1, px, py);
    q2  = quadrant_of(x2, y2, px, py);
    sum = edge_turn(q2, q0, x2, y2, x0, y0, px, py) +
          edge_turn(q0, q1, x0, y0, x1, y1, px, py) +
          edge_turn(q1, q2, x1, y1, x2, y2, px, py);
    v.in_tri = (sum != 0);
    v.wind   = pitw_pkg::wind_t'(sum);
    return v;
  endfunction

  // ---------------------------------------------------------------------
  // random triangles
  // ---------------------------------------------------------------------

  function automatic coord_t draw_coord(scale_t s);
    int v;
    case (s)
      SCALE_SMALL:   v = int'($urandom_range(0, 127)) - 64;
      SCALE_EXTREME: v = EXTREME_VALS[$urandom_range(0, 7)];
      default:       v = int'($urandom);
    endcase
    return coord_t'(v);
  endfunction

  // uniform value within the span of three coordinates, ends included
  function automatic coord_t pick_between(coord_t a, coord_t b, coord_t c);
    int lo, hi;
    lo = a;
    hi = a;
    if (b < lo) lo = b;
    if (c < lo) lo = c;
    if (b > hi) hi = b;
    if (c > hi) hi = c;
    return coord_t'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic tri_item_t random_item();
    tri_item_t t;
    coord_t    vx [3];
    coord_t    vy [3];
    scale_t    s;
    shape_t    shape;
    int        pick;
    pick = $urandom_range(0, 9);
    s    = (pick < 4) ? SCALE_FULL : (pick < 8) ? SCALE_SMALL : SCALE_EXTREME;
    for (int i = 0; i < 3; i++) begin
      vx[i] = draw_coord(s);
      vy[i] = draw_coord(s);
    end
    // most points sit in the box so the winding walk is reached;
    // the free ones are mostly rejects and act as noise
    pick  = $urandom_range(0, 99);
    shape = (pick < 45) ? SHAPE_BOX : (pick < 70) ? SHAPE_CENTROID :
            (pick < 85) ? SHAPE_VERTEX : SHAPE_FREE;
    case (shape)
      SHAPE_BOX: begin
        t.px = pick_between(vx[0], vx[1], vx[2]);
        t.py = pick_between(vy[0], vy[1], vy[2]);
      end
      SHAPE_CENTROID: begin
        t.px = coord_t'((int'(vx[0]) + int'(vx[1]) + int'(vx[2])) / 3);
        t.py = coord_t'((int'(vy[0]) + int'(vy[1]) + int'(vy[2])) / 3);
      end
      SHAPE_VERTEX: begin
        // shares coordinates with vertices: box edges, corners and the vertex itself
        t.px = vx[$urandom_range(0, 2)];
        t.py = vy[$urandom_range(0, 2)];
      end
      default: begin
        t.px = draw_coord(s);
        t.py = draw_coord(s);
      end
    endcase
    t.x0 = vx[0]; t.y0 = vy[0];
    t.x1 = vx[1]; t.y1 = vy[1];
    t.x2 = vx[2]; t.y2 = vy[2];
    return t;
  endfunction

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input tri_item_t t, input verdict_t want);
    int gap;
    // every fourth stretch of 150 items goes back to back
    gap = ((items_sent / 150) % 4 == 3) ? 0 : int'($urandom_range(0, 3));
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_x <= t.px;
    point_y <= t.py;
    vert0_x <= t.x0;
    vert0_y <= t.y0;
    vert1_x <= t.x1;
    vert1_y <= t.y1;
    vert2_x <= t.x2;
    vert2_y <= t.y2;
    push    <= 1'b1;
    do @(posedge clk); while (full);
    winding_q.push_back(want);
    items_sent++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("tb: mismatch in %s at result %0d: got %0d, want %0d",
             what, results_taken, got, want);
  endtask

  // called at the rising edge of a result transfer
  task automatic check_result();
    verdict_t want;
    if (winding_q.size() == 0) begin
      report_mismatch("result with nothing pending", int'(winding), 0);
    end else begin
      want = winding_q.pop_front();
      if (inside_res !== want.in_tri)
        report_mismatch("inside_res", int'(inside_res), int'(want.in_tri));
      if (winding !== want.wind)
        report_mismatch("winding", int'(winding), int'($signed(want.wind)));
    end
    results_taken++;
  endtask

  initial begin : result_side
    int stall;
    while (rst) @(negedge clk);
    forever begin
      // a couple of long hold-offs so the block fills and raises full
      if (results_taken == 300 || results_taken == 900)
        stall = HOLD_OFF_CYCLES;
      else if ((results_taken / 150) % 4 == 1)
        stall = 0;
      else
        stall = $urandom_range(0, 3);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      check_result();
      @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: any stretch with no transfer at all on either side
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // reset, stimulus and end of run
  // ---------------------------------------------------------------------

  initial begin : stimulus
    tri_item_t t;
    verdict_t  want;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table: typed answers where they are plain, predictor elsewhere
    for (int r = 0; r < NUM_ROWS; r++) begin
      t.px = coord_t'(dir_rows[r].px);
      t.py = coord_t'(dir_rows[r].py);
      t.x0 = coord_t'(dir_rows[r].x0);
      t.y0 = coord_t'(dir_rows[r].y0);
      t.x1 = coord_t'(dir_rows[r].x1);
      t.y1 = coord_t'(dir_rows[r].y1);
      t.x2 = coord_t'(dir_rows[r].x2);
      t.y2 = coord_t'(dir_rows[r].y2);
      want = predict_winding(t);
      if (dir_rows[r].typed) begin
        want.in_tri = dir_rows[r].in_tri;
        want.wind   = pitw_pkg::wind_t'(dir_rows[r].wind);
      end
      send_item(t, want);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      t = random_item();
      send_item(t, predict_winding(t));
    end
    push <= 1'b0;

    // wait for every verdict to be matched, then let stray results show up
    while (winding_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
